// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the request selector RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define FEDF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("request selector assertion failed");

// Condition must never be true outside reset
`define FEDF_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("request selector forbidden condition seen");

`else

`define FEDF_ASSERT(label, clk, rst_n, prop)
`define FEDF_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- rtl/fedf_pkg.sv -----
// Types and constants shared by the request selector controller and datapath
package fedf_pkg;

    localparam int ID_W     = 4;
    localparam int TIME_W   = 32;
    localparam int DL_W     = 33;
    localparam int MASK_W   = 16;
    localparam int ID_COUNT = 16;

    // Input transaction layout
    localparam int IN_TDATA_W = 56;
    localparam int IN_TUSER_W = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURNOUT = 1'd1;

    localparam logic MODE_FIFO = 1'b0;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SELECT = 2'd2
    } op_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [DL_W-1:0] deadline;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic push;
        logic scan_start;
        logic scan_step;
        logic set_found;
        logic shift_wr;
        logic cnt_dec;
        logic sel_clear;
        logic sel_update;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic chk_valid;
        logic chk_match;
        logic reads_done;
        logic out_busy;
    } status_t;

endpackage

// ----- rtl/fifo_edf_request_selector.sv -----
// Top level of the FIFO / earliest-deadline-first request selector
// Each transaction on the slave side is one operation on an ordered queue of up to
// QUEUE_DEPTH requesters and gives one result transaction on the master side. A push
// passes through the execute and finish states before its result is registered; a select
// scans the N queued entries through the memory's single registered read port, one per
// cycle; a remove scans up to the matching entry and then moves every later entry up by
// one through the same port, each read overlapping the write of the entry before it. One
// operation is in progress at a time; the next is taken once the result is in the output
// register, even while that result still waits for m_tready. Configuration must be
// written only while the block is idle; the block itself does not enforce this. Queue
// entries need no clearing after reset.
module fifo_edf_request_selector
    import fedf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Operation stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // requester_id[3:0], start_time[35:4], eligible_mask[51:36], zero pad
    input  logic [IN_TDATA_W-1:0] s_tdata,
    // op[1:0]
    input  logic [IN_TUSER_W-1:0] s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // grant_valid[0], grant_id[4:1], push_dropped[5], pop_found[6],
    // entry_count[7 +: CNT_W], zero pad
    output logic [((7 + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W = ((7 + CNT_W + 7) / 8) * 8;

    cmd_t    cmd;
    status_t st;

    fedf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    fedf_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W),
        .OUT_W       (OUT_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

// ----- rtl/fedf_ctrl.sv -----
// Sequencer for push, remove and select transactions of the request selector
module fedf_ctrl
    import fedf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SHIFT,
        ST_SELECT,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (st.op)
                    OP_PUSH:
                    begin
                        cmd.push   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    OP_REMOVE:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    OP_SELECT:
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.sel_clear  = 1'b1;
                        state_next     = ST_SELECT;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                priority if (st.chk_valid && st.chk_match)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = ST_SHIFT;
                end
                else if (st.reads_done && !st.chk_valid)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT:
            begin
                cmd.scan_step = 1'b1;
                cmd.shift_wr  = 1'b1;
                if (st.reads_done && !st.chk_valid)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_SELECT:
            begin
                cmd.scan_step  = 1'b1;
                cmd.sel_update = 1'b1;
                if (st.reads_done && !st.chk_valid)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!st.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// ----- rtl/fedf_dp.sv -----
// Queue storage, scan pipeline, selection tracking and result register
module fedf_dp
    import fedf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int CNT_W       = 5,
    parameter int OUT_W       = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic [IN_TUSER_W-1:0] s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    input  cmd_t                  cmd,
    output status_t               st
);

    `include "assert_macros.svh"

    localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int RES_W = 7 + CNT_W;

    // Configuration registers
    logic              mode_reg;
    logic [TIME_W-1:0] burnout_reg;

    // Latched input transaction
    op_t               op_reg;
    logic [ID_W-1:0]   in_id_reg;
    logic [TIME_W-1:0] start_reg;
    logic [MASK_W-1:0] mask_reg;

    // Queue state
    entry_t            mem [QUEUE_DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    entry_t            rd_data_reg;
    logic [AW-1:0]     chk_idx_reg;
    logic              chk_valid_reg;

    // Per-transaction flags and selection
    logic              found_reg;
    logic              dropped_reg;
    logic              have_reg;
    logic [ID_W-1:0]   best_id_reg;
    logic [DL_W-1:0]   best_dl_reg;

    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic              full;
    logic              reads_done;
    logic              rd_issue;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    entry_t            mem_wdata;
    logic              eligible;
    logic              better;
    logic              take;
    logic [DL_W-1:0]   new_deadline;
    logic [RES_W-1:0]  result;

    assign full         = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign reads_done   = (idx_reg >= count_reg);
    assign rd_issue     = cmd.scan_step && !reads_done;
    assign new_deadline = {1'b0, start_reg} + {1'b0, burnout_reg};

    // Single write port: append on push, move one entry up during removal
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[AW-1:0];
        mem_wdata = '{id: in_id_reg, deadline: new_deadline};
        priority if (cmd.push && !full)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.shift_wr && chk_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = chk_idx_reg - 1'b1;
            mem_wdata = rd_data_reg;
        end
    end

    // Entry memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_issue)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
            chk_idx_reg <= idx_reg[AW-1:0];
        end
    end

    // Selection compare on the entry just read
    always_comb
    begin
        eligible = (32'(rd_data_reg.id) < ID_COUNT) && mask_reg[rd_data_reg.id];
        better   = (rd_data_reg.deadline < best_dl_reg) ||
                   ((rd_data_reg.deadline == best_dl_reg) &&
                    (rd_data_reg.id > best_id_reg));
        if (mode_reg == MODE_FIFO)
        begin
            take = cmd.sel_update && chk_valid_reg && eligible && !have_reg;
        end
        else
        begin
            take = cmd.sel_update && chk_valid_reg && eligible && (!have_reg || better);
        end
    end

    // Selection payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_id_reg <= rd_data_reg.id;
            best_dl_reg <= rd_data_reg.deadline;
        end
    end

    // Input transaction payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg    <= op_t'(s_tuser);
            in_id_reg <= s_tdata[ID_W-1:0];
            start_reg <= s_tdata[ID_W+TIME_W-1:ID_W];
            mask_reg  <= s_tdata[ID_W+TIME_W+MASK_W-1:ID_W+TIME_W];
        end
    end

    // Result fields, lowest bit first
    always_comb
    begin
        result = '0;
        result[0]       = (op_reg == OP_SELECT) && have_reg;
        result[4:1]     = ((op_reg == OP_SELECT) && have_reg) ? best_id_reg : '0;
        result[5]       = (op_reg == OP_PUSH) && dropped_reg;
        result[6]       = (op_reg == OP_REMOVE) && found_reg;
        result[RES_W-1:7] = count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= OUT_W'(result);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            burnout_reg   <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Configuration writes
            if (cfg_we && (cfg_index == CFG_MODE))
            begin
                mode_reg <= cfg_data[0];
            end
            if (cfg_we && (cfg_index == CFG_BURNOUT))
            begin
                burnout_reg <= cfg_data[TIME_W-1:0];
            end

            if (cmd.load_in)
            begin
                found_reg   <= 1'b0;
                dropped_reg <= 1'b0;
            end

            // Push: append or drop
            if (cmd.push)
            begin
                dropped_reg <= full;
                if (!full)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - 1'b1;
            end

            // Scan read pointer
            if (cmd.scan_start)
            begin
                idx_reg       <= '0;
                chk_valid_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                chk_valid_reg <= rd_issue;
                if (rd_issue)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end

            if (cmd.set_found)
            begin
                found_reg <= 1'b1;
            end

            if (cmd.sel_clear)
            begin
                have_reg <= 1'b0;
            end
            else if (take)
            begin
                have_reg <= 1'b1;
            end

            // Output register
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign st.op         = op_reg;
    assign st.chk_valid  = chk_valid_reg;
    assign st.chk_match  = (rd_data_reg.id == in_id_reg);
    assign st.reads_done = reads_done;
    assign st.out_busy   = out_valid_reg && !m_tready;

    `FEDF_NEVER(a_count_bound, clk, rst_n, count_reg > CNT_W'(QUEUE_DEPTH))
    `FEDF_ASSERT(a_shift_addr, clk, rst_n, (cmd.shift_wr && chk_valid_reg) |-> (chk_idx_reg != '0))
    `FEDF_ASSERT(a_dec_nonempty, clk, rst_n, cmd.cnt_dec |-> (count_reg != '0))
    `FEDF_ASSERT(a_push_full_hold, clk, rst_n, (cmd.push && full) |=> (count_reg == $past(count_reg)))

endmodule
